// ===== design/mi3_pkg.sv =====
// Shared types, codes and index tables for the 3x3 matrix inverse pipeline.
package mi3_pkg;

    localparam logic [1:0] CMD_INV = 2'd0;
    localparam logic [1:0] CMD_ADJ = 2'd1;
    localparam logic [1:0] CMD_DET = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SING = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef logic [31:0] t_word;
    // element k = row*3 + col
    typedef logic [8:0][31:0] t_mat;

    // cofactor k = a*b - c*d, entries are matrix element indexes
    localparam int unsigned COF_IDX [9][4] = '{
        '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
        '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
        '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
    };

    // result element k takes cofactor TR_IDX[k] (transpose)
    localparam int unsigned TR_IDX [9] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

    typedef struct packed {
        logic [1:0] cmd;
        logic       sat;
    } t_ctl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       sat;
        logic       sing;
        logic [8:0] neg;
        t_word      den;
        t_mat       cof;
        t_word      det;
    } t_side;

    // returns {saturated, value}
    function automatic logic [32:0] sat32(input logic signed [65:0] x);
        logic [32:0] r;
        if (x > $signed(66'h0_7FFF_FFFF)) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (x < -$signed(66'h0_8000_0000)) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, x[31:0]};
        end
        return r;
    endfunction

endpackage

// ===== design/mi3_cof.sv =====
// Cofactor stages: 18 products, then difference, floor shift and saturate.
module mi3_cof #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [1:0]    i_cmd,
    input  mi3_pkg::t_mat i_mat,
    output logic          o_vld,
    output mi3_pkg::t_ctl o_ctl,
    output mi3_pkg::t_mat o_cof,
    output mi3_pkg::t_mat o_mat
);
    import mi3_pkg::*;

    logic signed [63:0] r_p [9];
    logic signed [63:0] r_q [9];
    t_mat               r_m1;
    logic [1:0]         r_cmd;
    logic               r_vld1;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_p[k] <= $signed(i_mat[COF_IDX[k][0]]) * $signed(i_mat[COF_IDX[k][1]]);
            r_q[k] <= $signed(i_mat[COF_IDX[k][2]]) * $signed(i_mat[COF_IDX[k][3]]);
        end
        r_m1  <= i_mat;
        r_cmd <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
        end
    end

    t_mat        n_cof;
    logic [8:0]  n_sat;

    always_comb begin
        logic signed [64:0] diff;
        logic signed [64:0] shf;
        logic [32:0]        s;
        for (int k = 0; k < 9; k++) begin
            diff     = $signed({r_p[k][63], r_p[k]}) - $signed({r_q[k][63], r_q[k]});
            shf      = diff >>> FRAC_BITS;
            s        = sat32({shf[64], shf});
            n_cof[k] = s[31:0];
            n_sat[k] = s[32];
        end
    end

    t_mat r_cof;
    t_mat r_m2;
    t_ctl r_ctl;
    logic r_vld2;

    always_ff @(posedge i_clk) begin
        r_cof     <= n_cof;
        r_m2      <= r_m1;
        r_ctl.cmd <= r_cmd;
        r_ctl.sat <= |n_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
    end

    assign o_vld = r_vld2;
    assign o_ctl = r_ctl;
    assign o_cof = r_cof;
    assign o_mat = r_m2;

endmodule

// ===== design/mi3_det.sv =====
// Determinant stages: bottom row times its cofactors, then sum, floor and saturate.
module mi3_det #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  mi3_pkg::t_ctl i_ctl,
    input  mi3_pkg::t_mat i_cof,
    input  mi3_pkg::t_mat i_mat,
    output logic          o_vld,
    output mi3_pkg::t_ctl o_ctl,
    output mi3_pkg::t_mat o_cof,
    output mi3_pkg::t_word o_det
);
    import mi3_pkg::*;

    logic signed [63:0] r_d [3];
    t_mat               r_cof1;
    t_ctl               r_ctl1;
    logic               r_vld1;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_d[j] <= $signed(i_mat[6 + j]) * $signed(i_cof[6 + j]);
        end
        r_cof1 <= i_cof;
        r_ctl1 <= i_ctl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
        end
    end

    logic signed [65:0] sum;
    logic signed [65:0] shf;
    logic [32:0]        s;

    assign sum = $signed({{2{r_d[0][63]}}, r_d[0]}) + $signed({{2{r_d[1][63]}}, r_d[1]})
               + $signed({{2{r_d[2][63]}}, r_d[2]});
    assign shf = sum >>> FRAC_BITS;
    assign s   = sat32(shf);

    t_mat  r_cof2;
    t_ctl  r_ctl2;
    t_word r_det;
    logic  r_vld2;

    always_ff @(posedge i_clk) begin
        r_cof2     <= r_cof1;
        r_ctl2.cmd <= r_ctl1.cmd;
        r_ctl2.sat <= r_ctl1.sat | s[32];
        r_det      <= s[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
    end

    assign o_vld = r_vld2;
    assign o_ctl = r_ctl2;
    assign o_cof = r_cof2;
    assign o_det = r_det;

endmodule

// ===== design/mi3_div.sv =====
// Nine-lane pipelined restoring divider, one quotient bit per stage.
module mi3_div #(
    parameter int FRAC_BITS = 16,
    localparam int NW = 32 + FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [8:0][NW-1:0]   i_num,
    input  mi3_pkg::t_side       i_side,
    output logic                 o_vld,
    output logic [8:0][NW-1:0]   o_quo,
    output mi3_pkg::t_side       o_side
);
    import mi3_pkg::*;

    logic [31:0]   r_rem  [NW][9];
    logic [NW-1:0] r_nq   [NW][9];
    t_side         r_side [NW];
    logic [NW-1:0] r_vld;

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [31:0]   rem_in [9];
        logic [NW-1:0] nq_in  [9];
        t_side         side_in;
        logic          vld_in;

        if (s == 0) begin : g_first
            for (genvar l = 0; l < 9; l++) begin : g_in
                assign rem_in[l] = '0;
                assign nq_in[l]  = i_num[l];
            end
            assign side_in = i_side;
            assign vld_in  = i_vld;
        end else begin : g_next
            for (genvar l = 0; l < 9; l++) begin : g_in
                assign rem_in[l] = r_rem[s-1][l];
                assign nq_in[l]  = r_nq[s-1][l];
            end
            assign side_in = r_side[s-1];
            assign vld_in  = r_vld[s-1];
        end

        for (genvar l = 0; l < 9; l++) begin : g_lane
            logic [32:0] trial;
            logic        ge;
            assign trial = {rem_in[l], nq_in[l][NW-1]};
            assign ge    = trial >= {1'b0, side_in.den};
            always_ff @(posedge i_clk) begin
                r_rem[s][l] <= ge ? 32'(trial - {1'b0, side_in.den}) : trial[31:0];
                r_nq[s][l]  <= {nq_in[l][NW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[s] <= side_in;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
        end
    end

    for (genvar l = 0; l < 9; l++) begin : g_out
        assign o_quo[l] = r_nq[NW-1][l];
    end
    assign o_side = r_side[NW-1];
    assign o_vld  = r_vld[NW-1];

endmodule

// ===== design/matrix3x3_inverse.sv =====
// Top level of the 3x3 matrix inverse / adjugate / determinant pipeline.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  command  | start, busy             | i_command, i_a00 .. i_a22
//  result   | o_strobe (one cycle)    | o_r00 .. o_r22, o_det_value, o_status
//  config   | i_cfg_we                | i_cfg_wdata (epsilon)
//
// One beat per cycle in, one result beat per cycle out; busy is always low.
// The pipeline has two cofactor stages, two determinant stages, one divider
// setup stage, one stage per quotient bit and one output stage.
// The divider depth (one quotient bit a stage) sets the latency.
// Synchronous active-low reset clears valid bits; epsilon resets to 1.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module matrix3x3_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic signed [31:0] i_a00,
    input  logic signed [31:0] i_a01,
    input  logic signed [31:0] i_a02,
    input  logic signed [31:0] i_a10,
    input  logic signed [31:0] i_a11,
    input  logic signed [31:0] i_a12,
    input  logic signed [31:0] i_a20,
    input  logic signed [31:0] i_a21,
    input  logic signed [31:0] i_a22,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic signed [31:0] o_r00,
    output logic signed [31:0] o_r01,
    output logic signed [31:0] o_r02,
    output logic signed [31:0] o_r10,
    output logic signed [31:0] o_r11,
    output logic signed [31:0] o_r12,
    output logic signed [31:0] o_r20,
    output logic signed [31:0] o_r21,
    output logic signed [31:0] o_r22,
    output logic signed [31:0] o_det_value,
    output logic [1:0]  o_status
);
    import mi3_pkg::*;

    localparam int NW  = 32 + FRAC_BITS;
    localparam int LAT = 6 + NW;

    logic [30:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= 31'd1;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    assign busy = 1'b0;

    logic in_vld;
    t_mat in_mat;
    assign in_vld = start && !busy;
    assign in_mat = {i_a22, i_a21, i_a20, i_a12, i_a11, i_a10, i_a02, i_a01, i_a00};

    logic c_vld;
    t_ctl c_ctl;
    t_mat c_cof;
    t_mat c_mat;

    mi3_cof #(.FRAC_BITS(FRAC_BITS)) u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (in_vld),
        .i_cmd   (i_command),
        .i_mat   (in_mat),
        .o_vld   (c_vld),
        .o_ctl   (c_ctl),
        .o_cof   (c_cof),
        .o_mat   (c_mat)
    );

    logic  d_vld;
    t_ctl  d_ctl;
    t_mat  d_cof;
    t_word d_det;

    mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (c_vld),
        .i_ctl   (c_ctl),
        .i_cof   (c_cof),
        .i_mat   (c_mat),
        .o_vld   (d_vld),
        .o_ctl   (d_ctl),
        .o_cof   (d_cof),
        .o_det   (d_det)
    );

    // divider setup: magnitudes of numerators and determinant, result signs
    logic [31:0]         mag;
    logic [8:0][NW-1:0]  n_num;
    logic [8:0]          n_neg;

    assign mag = d_det[31] ? (~d_det + 32'd1) : d_det;

    always_comb begin
        logic signed [NW-1:0] sn;
        for (int k = 0; k < 9; k++) begin
            sn       = NW'($signed(d_cof[TR_IDX[k]])) <<< FRAC_BITS;
            n_num[k] = sn[NW-1] ? NW'(-sn) : NW'(sn);
            n_neg[k] = d_cof[TR_IDX[k]][31] ^ d_det[31];
        end
    end

    logic [8:0][NW-1:0] r_num;
    t_side              r_side;
    logic               r_svld;

    always_ff @(posedge i_clk) begin
        r_num       <= n_num;
        r_side.cmd  <= d_ctl.cmd;
        r_side.sat  <= d_ctl.sat;
        r_side.sing <= (d_ctl.cmd == CMD_INV) && (mag <= {1'b0, r_eps});
        r_side.neg  <= n_neg;
        r_side.den  <= mag;
        r_side.cof  <= d_cof;
        r_side.det  <= d_det;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svld <= 1'b0;
        end else begin
            r_svld <= d_vld;
        end
    end

    logic               q_vld;
    logic [8:0][NW-1:0] q_quo;
    t_side              q_side;

    mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_svld),
        .i_num   (r_num),
        .i_side  (r_side),
        .o_vld   (q_vld),
        .o_quo   (q_quo),
        .o_side  (q_side)
    );

    // final sign, saturation and selection
    t_mat       n_res;
    logic [8:0] n_lsat;
    logic [1:0] n_status;
    logic       do_inv;

    assign do_inv = (q_side.cmd == CMD_INV) && !q_side.sing;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            logic [31:0] qv;
            qv        = '0;
            n_lsat[k] = 1'b0;
            if (q_side.neg[k]) begin
                if (q_quo[k] > {{(NW-32){1'b0}}, 32'h8000_0000}) begin
                    n_lsat[k] = 1'b1;
                    qv        = 32'h8000_0000;
                end else begin
                    qv = ~q_quo[k][31:0] + 32'd1;
                end
            end else begin
                if (q_quo[k] > {{(NW-32){1'b0}}, 32'h7FFF_FFFF}) begin
                    n_lsat[k] = 1'b1;
                    qv        = 32'h7FFF_FFFF;
                end else begin
                    qv = q_quo[k][31:0];
                end
            end
            if (q_side.cmd == CMD_ADJ) begin
                n_res[k] = q_side.cof[TR_IDX[k]];
            end else if (do_inv) begin
                n_res[k] = qv;
            end else begin
                n_res[k] = '0;
            end
        end
        if (q_side.sing) begin
            n_status = ST_SING;
        end else if (q_side.sat || (do_inv && (|n_lsat))) begin
            n_status = ST_SAT;
        end else begin
            n_status = ST_OK;
        end
    end

    t_mat       r_res;
    t_word      r_det;
    logic [1:0] r_status;
    logic       r_ovld;

    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_det    <= q_side.det;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= q_vld;
        end
    end

    assign o_strobe    = r_ovld;
    assign o_r00       = r_res[0];
    assign o_r01       = r_res[1];
    assign o_r02       = r_res[2];
    assign o_r10       = r_res[3];
    assign o_r11       = r_res[4];
    assign o_r12       = r_res[5];
    assign o_r20       = r_res[6];
    assign o_r21       = r_res[7];
    assign o_r22       = r_res[8];
    assign o_det_value = r_det;
    assign o_status    = r_status;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_strobe)
        else $error("accepted beat did not come out after the pipeline latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(i_rst_n, LAT) |-> $past(start, LAT))
        else $error("result beat without a matching accepted beat");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status == ST_SING |-> o_r00 == 0 && o_r11 == 0 && o_r22 == 0
            && o_r01 == 0 && o_r02 == 0 && o_r10 == 0 && o_r12 == 0
            && o_r20 == 0 && o_r21 == 0)
        else $error("singular result carries nonzero elements");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_status != 2'd3)
        else $error("status code out of range");

endmodule
